/* hw/rtl/ipp_pkg.sv */
// ----------------------------------------------------------------------------
// ipp_pkg
// Shared types, constants and the arctangent table for the IP address polar
// plot pipeline.
// ----------------------------------------------------------------------------
package ipp_pkg;

  // Output fraction bits and the number of rotation steps by default.
  localparam int unsigned FRAC_BITS      = 12;
  localparam int unsigned ROTATION_STEPS = 14;
  // The arctangent table has this many entries; more steps are not used.
  localparam int unsigned MAX_STEPS      = 24;

  // Internal Q30 datapath widths.  The vector never grows past about 2^34
  // and the residual angle stays within +/-2^31.
  localparam int unsigned XY_W = 36;
  localparam int unsigned Z_W  = 33;

  // Address folding constants.
  localparam int unsigned MOD_SPAN     = 10000;
  localparam int unsigned QUARTER_SPAN = MOD_SPAN / 4;
  localparam int unsigned MOD_FOLDS    = 65535 / MOD_SPAN;

  // Start vector gain: K * 8 * 2^30, split into integer and remainder parts
  // of a division by the span so that no wide divider is needed.
  localparam longint unsigned GAIN_X = 64'd652032874 * 64'd8;
  localparam int unsigned     X_INT  = int'(GAIN_X / MOD_SPAN);
  localparam int unsigned     X_REM  = int'(GAIN_X % MOD_SPAN);
  // Angle scale: 2*pi*2^30, split the same way.
  localparam longint unsigned TWO_PI = 64'd6746518852;
  localparam int unsigned     Z_INT  = int'(TWO_PI / MOD_SPAN);
  localparam int unsigned     Z_REM  = int'(TWO_PI % MOD_SPAN);

  // Reciprocal of the span for the small exact divisions.
  localparam int unsigned RECIP_SH = 37;
  localparam int unsigned RECIP    = int'((64'd1 << RECIP_SH) / MOD_SPAN);

  // Output rounding.
  localparam int unsigned OUT_SH = 30 - FRAC_BITS;

  typedef enum logic [1:0] {
    QUAD_I,
    QUAD_II,
    QUAD_III,
    QUAD_IV
  } quad_t;

  typedef struct packed {
    logic        has_ip;
    logic        pick_source;
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
  } in_beat_t;

  typedef struct packed {
    logic               no_ip;
    logic signed [15:0] out_y;
    logic signed [15:0] out_z;
  } out_beat_t;

  // One beat travelling down the rotation chain.
  typedef struct packed {
    logic                  valid;
    logic                  no_ip;
    quad_t                 quad;
    logic signed [XY_W-1:0] x;
    logic signed [XY_W-1:0] y;
    logic signed [Z_W-1:0]  z;
  } rot_beat_t;

  // atan(2^-step) in Q30, truncated.
  function automatic logic signed [Z_W-1:0] atan_q30(input int unsigned step);
    logic [31:0] v;
    case (step)
      0:       v = 32'h3243F6A8;
      1:       v = 32'h1DAC6705;
      2:       v = 32'h0FADBAFC;
      3:       v = 32'h07F56EA6;
      4:       v = 32'h03FEAB76;
      5:       v = 32'h01FFD55B;
      6:       v = 32'h00FFFAAA;
      7:       v = 32'h007FFF55;
      8:       v = 32'h003FFFEA;
      9:       v = 32'h001FFFFD;
      10:      v = 32'h000FFFFF;
      11:      v = 32'h0007FFFF;
      12:      v = 32'h0003FFFF;
      13:      v = 32'h0001FFFF;
      14:      v = 32'h0000FFFF;
      15:      v = 32'h00007FFF;
      16:      v = 32'h00003FFF;
      17:      v = 32'h00001FFF;
      18:      v = 32'h00000FFF;
      19:      v = 32'h000007FF;
      20:      v = 32'h000003FF;
      21:      v = 32'h000001FF;
      22:      v = 32'h000000FF;
      23:      v = 32'h0000007F;
      default: v = 32'h00000000;
    endcase
    return $signed(Z_W'(v));
  endfunction

endpackage

/* hw/rtl/ipp_prep.sv */
// ----------------------------------------------------------------------------
// ipp_prep
// Front end: picks the address, folds both halves by the span, splits the
// angle into a quadrant and remainder and builds the Q30 start vector.
// ----------------------------------------------------------------------------
module ipp_prep (
  input  logic              clk,
  input  logic              rst,
  input  logic              pkt_valid,
  output logic              pkt_stall,
  input  ipp_pkg::in_beat_t pkt,
  input  logic              ready_next,
  output ipp_pkg::rot_beat_t cur
);
  import ipp_pkg::*;

  localparam logic [24:0] SPAN25  = 25'(MOD_SPAN);
  localparam logic [24:0] HALF25  = 25'(MOD_SPAN / 2);
  localparam logic [24:0] XREM25  = 25'(X_REM);
  localparam logic [24:0] ZREM25  = 25'(Z_REM);
  localparam logic [33:0] XINT34  = 34'(X_INT);
  localparam logic [30:0] ZINT31  = 31'(Z_INT);
  localparam logic [48:0] RECIP49 = 49'(RECIP);

  // Reduce a 16-bit value by the span using parallel threshold compares.
  function automatic logic [13:0] fold(input logic [15:0] v);
    logic [16:0] res;
    res = {1'b0, v};
    for (int k = 1; k <= MOD_FOLDS; k++) begin
      if ({1'b0, v} >= 17'(k * MOD_SPAN)) begin
        res = {1'b0, v} - 17'(k * MOD_SPAN);
      end
    end
    return res[13:0];
  endfunction

  // Stage valids and per-stage load enables (bubbles collapse).
  logic [5:0] v;
  logic [5:0] ld;

  assign ld[5] = !v[5] || ready_next;
  assign ld[4] = !v[4] || ld[5];
  assign ld[3] = !v[3] || ld[4];
  assign ld[2] = !v[2] || ld[3];
  assign ld[1] = !v[1] || ld[2];
  assign ld[0] = !v[0] || ld[1];
  assign pkt_stall = !ld[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (ld[0]) v[0] <= pkt_valid;
      for (int k = 1; k < 6; k++) begin
        if (ld[k]) v[k] <= v[k-1];
      end
    end
  end

  // Stage A: address select.
  logic        a_no_ip;
  logic [31:0] a_addr;
  // Stage B: folded halves.
  logic        b_no_ip;
  logic [13:0] b_r;
  logic [13:0] b_a;
  // Stage C: quadrant and remainder.
  logic        c_no_ip;
  quad_t       c_quad;
  logic [13:0] c_r;
  logic [11:0] c_m;
  // Stage D: split products.
  logic        d_no_ip;
  quad_t       d_quad;
  logic [24:0] d_pr;
  logic [24:0] d_pm;
  logic [33:0] d_bx;
  logic [30:0] d_bz;
  // Stage E: quotient estimates.
  logic        e_no_ip;
  quad_t       e_quad;
  logic [24:0] e_pr;
  logic [24:0] e_pm;
  logic [33:0] e_bx;
  logic [30:0] e_bz;
  logic [11:0] e_tr;
  logic [11:0] e_tm;
  // Stage F: start vector.
  logic        f_no_ip;
  quad_t       f_quad;
  logic [33:0] f_x;
  logic [30:0] f_z;

  quad_t       c_quad_next;
  logic [13:0] c_base;
  logic [48:0] e_prod_r;
  logic [48:0] e_prod_m;
  logic [24:0] f_rem_r;
  logic [24:0] f_rem_m;

  always_comb begin
    if (b_a >= 14'(3 * QUARTER_SPAN)) begin
      c_quad_next = QUAD_IV;
      c_base      = 14'(3 * QUARTER_SPAN);
    end else if (b_a >= 14'(2 * QUARTER_SPAN)) begin
      c_quad_next = QUAD_III;
      c_base      = 14'(2 * QUARTER_SPAN);
    end else if (b_a >= 14'(QUARTER_SPAN)) begin
      c_quad_next = QUAD_II;
      c_base      = 14'(QUARTER_SPAN);
    end else begin
      c_quad_next = QUAD_I;
      c_base      = '0;
    end
  end

  assign e_prod_r = {24'b0, d_pr} * RECIP49;
  assign e_prod_m = {24'b0, d_pm} * RECIP49;
  assign f_rem_r  = e_pr - ({13'b0, e_tr} * SPAN25);
  assign f_rem_m  = e_pm - ({13'b0, e_tm} * SPAN25);

  always_ff @(posedge clk) begin
    if (ld[0]) begin
      a_no_ip <= !pkt.has_ip;
      a_addr  <= pkt.pick_source ? pkt.src_addr : pkt.dst_addr;
    end
    if (ld[1]) begin
      b_no_ip <= a_no_ip;
      b_r     <= fold(a_addr[31:16]);
      b_a     <= fold(a_addr[15:0]);
    end
    if (ld[2]) begin
      c_no_ip <= b_no_ip;
      c_quad  <= c_quad_next;
      c_r     <= b_r;
      c_m     <= 12'(b_a - c_base);
    end
    if (ld[3]) begin
      d_no_ip <= c_no_ip;
      d_quad  <= c_quad;
      d_pr    <= {11'b0, c_r} * XREM25 + HALF25;
      d_pm    <= {13'b0, c_m} * ZREM25 + HALF25;
      d_bx    <= {20'b0, c_r} * XINT34;
      d_bz    <= {19'b0, c_m} * ZINT31;
    end
    if (ld[4]) begin
      e_no_ip <= d_no_ip;
      e_quad  <= d_quad;
      e_pr    <= d_pr;
      e_pm    <= d_pm;
      e_bx    <= d_bx;
      e_bz    <= d_bz;
      e_tr    <= e_prod_r[RECIP_SH +: 12];
      e_tm    <= e_prod_m[RECIP_SH +: 12];
    end
    if (ld[5]) begin
      f_no_ip <= e_no_ip;
      f_quad  <= e_quad;
      // The reciprocal estimate is low by at most one.
      f_x     <= e_bx + 34'(e_tr) + 34'(f_rem_r >= SPAN25);
      f_z     <= e_bz + 31'(e_tm) + 31'(f_rem_m >= SPAN25);
    end
  end

  always_comb begin
    cur.valid = v[5];
    cur.no_ip = f_no_ip;
    cur.quad  = f_quad;
    cur.x     = $signed(XY_W'(f_x));
    cur.y     = '0;
    cur.z     = $signed(Z_W'(f_z));
  end

endmodule

/* hw/rtl/ipp_cell.sv */
// ----------------------------------------------------------------------------
// ipp_cell
// One rotation step of the chain: rotates the vector by +/- atan(2^-STEP)
// toward a zero residual angle and hands the result to the next cell.
// ----------------------------------------------------------------------------
module ipp_cell #(
  parameter int unsigned STEP = 0
) (
  input  logic               clk,
  input  logic               rst,
  input  ipp_pkg::rot_beat_t prev,
  input  logic               ready_next,
  output logic               ready_prev,
  output ipp_pkg::rot_beat_t cur
);
  import ipp_pkg::*;

  localparam logic signed [Z_W-1:0] ANGLE = atan_q30(STEP);

  logic                   valid;
  logic                   no_ip;
  quad_t                  quad;
  logic signed [XY_W-1:0] x;
  logic signed [XY_W-1:0] y;
  logic signed [Z_W-1:0]  z;

  logic signed [XY_W-1:0] dx;
  logic signed [XY_W-1:0] dy;
  logic signed [XY_W-1:0] x_next;
  logic signed [XY_W-1:0] y_next;
  logic signed [Z_W-1:0]  z_next;

  assign ready_prev = !valid || ready_next;

  always_comb begin
    dx = $signed(prev.y) >>> STEP;
    dy = $signed(prev.x) >>> STEP;
    if (!prev.z[Z_W-1]) begin
      x_next = $signed(prev.x) - dx;
      y_next = $signed(prev.y) + dy;
      z_next = $signed(prev.z) - ANGLE;
    end else begin
      x_next = $signed(prev.x) + dx;
      y_next = $signed(prev.y) - dy;
      z_next = $signed(prev.z) + ANGLE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ready_prev) begin
      valid <= prev.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_prev) begin
      no_ip <= prev.no_ip;
      quad  <= prev.quad;
      x     <= x_next;
      y     <= y_next;
      z     <= z_next;
    end
  end

  always_comb begin
    cur.valid = valid;
    cur.no_ip = no_ip;
    cur.quad  = quad;
    cur.x     = x;
    cur.y     = y;
    cur.z     = z;
  end

endmodule

/* hw/rtl/ipp_post.sv */
// ----------------------------------------------------------------------------
// ipp_post
// Back end: restores the quadrant, rounds from Q30 to the output format,
// saturates to 16 bits and holds the result beat in the output register.
// ----------------------------------------------------------------------------
module ipp_post (
  input  logic               clk,
  input  logic               rst,
  input  ipp_pkg::rot_beat_t prev,
  output logic               ready_prev,
  output logic               pos_valid,
  input  logic               pos_stall,
  output ipp_pkg::out_beat_t pos
);
  import ipp_pkg::*;

  localparam logic signed [XY_W:0] RND    = (XY_W+1)'(1) <<< (OUT_SH - 1);
  localparam logic signed [XY_W:0] SAT_HI = (XY_W+1)'(32767);
  localparam logic signed [XY_W:0] SAT_LO = -(XY_W+1)'(32768);

  function automatic logic signed [15:0] round_sat(input logic signed [XY_W-1:0] v);
    logic signed [XY_W:0] sum;
    logic signed [XY_W:0] sh;
    sum = $signed({v[XY_W-1], v}) + RND;
    sh  = sum >>> OUT_SH;
    if (sh > SAT_HI) begin
      return 16'sh7FFF;
    end else if (sh < SAT_LO) begin
      return -16'sh8000;
    end
    return $signed(sh[15:0]);
  endfunction

  logic                   s1_valid;
  logic                   s1_no_ip;
  logic signed [XY_W-1:0] s1_c;
  logic signed [XY_W-1:0] s1_s;
  logic                   ld1;
  logic                   ld2;
  logic signed [XY_W-1:0] c_next;
  logic signed [XY_W-1:0] s_next;

  assign ld2        = !pos_valid || !pos_stall;
  assign ld1        = !s1_valid || ld2;
  assign ready_prev = ld1;

  always_comb begin
    unique case (prev.quad)
      QUAD_I: begin
        c_next = prev.x;
        s_next = prev.y;
      end
      QUAD_II: begin
        c_next = -prev.y;
        s_next = prev.x;
      end
      QUAD_III: begin
        c_next = -prev.x;
        s_next = -prev.y;
      end
      QUAD_IV: begin
        c_next = prev.y;
        s_next = -prev.x;
      end
      default: begin
        c_next = prev.x;
        s_next = prev.y;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      pos_valid <= 1'b0;
    end else begin
      if (ld1) s1_valid <= prev.valid;
      if (ld2) pos_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ld1) begin
      s1_no_ip <= prev.no_ip;
      s1_c     <= c_next;
      s1_s     <= s_next;
    end
    if (ld2) begin
      pos.no_ip <= s1_no_ip;
      pos.out_y <= s1_no_ip ? 16'sd0 : round_sat(s1_s);
      pos.out_z <= s1_no_ip ? 16'sd0 : round_sat(s1_c);
    end
  end

endmodule

/* hw/rtl/ip_address_polar_plot.sv */
// ----------------------------------------------------------------------------
// ip_address_polar_plot
// Plots an IPv4 address as a point in the plane with a pipelined rotation
// chain.
// ----------------------------------------------------------------------------
// Each pkt beat names a source and a destination address and picks one of
// them. The upper half of the chosen address, reduced modulo 10000, sets a
// radius of 8*r/10000; the lower half, reduced the same way, sets an angle of
// 2*pi*a/10000. The pos beat returns radius*sin in out_y and radius*cos in
// out_z as signed 16-bit values with FRAC_BITS fraction bits, rounded half up
// and saturated. A packet without an IP header returns no_ip set and both
// coordinates zero. The block is fully pipelined and takes one pkt beat in
// every clock cycle while pkt_stall is low. Six front end stages fold the
// address and build the start vector, one cell per rotation step follows
// (at most MAX_STEPS cells), then a quadrant stage and the output register.
// Every stage holds its own valid bit, so empty stages fill up while pos is
// stalled, and pkt_stall rises only once the whole pipe is full.
// ----------------------------------------------------------------------------
module ip_address_polar_plot #(
  parameter int unsigned ROTATION_STEPS = ipp_pkg::ROTATION_STEPS
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               pkt_valid,
  output logic               pkt_stall,
  input  ipp_pkg::in_beat_t  pkt,
  output logic               pos_valid,
  input  logic               pos_stall,
  output ipp_pkg::out_beat_t pos
);
  import ipp_pkg::*;

  // Steps beyond the arctangent table are not performed.
  localparam int unsigned NCELLS =
    (ROTATION_STEPS < MAX_STEPS) ? ROTATION_STEPS : MAX_STEPS;

  // chain[i] feeds cell i; rdy[i] says the consumer of chain[i] can load.
  rot_beat_t chain [NCELLS+1];
  logic      rdy   [NCELLS+1];

  ipp_prep u_prep (
    .clk        (clk),
    .rst        (rst),
    .pkt_valid  (pkt_valid),
    .pkt_stall  (pkt_stall),
    .pkt        (pkt),
    .ready_next (rdy[0]),
    .cur        (chain[0])
  );

  for (genvar i = 0; i < NCELLS; i++) begin : g_cell
    ipp_cell #(
      .STEP (i)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .prev       (chain[i]),
      .ready_next (rdy[i+1]),
      .ready_prev (rdy[i]),
      .cur        (chain[i+1])
    );
  end

  ipp_post u_post (
    .clk        (clk),
    .rst        (rst),
    .prev       (chain[NCELLS]),
    .ready_prev (rdy[NCELLS]),
    .pos_valid  (pos_valid),
    .pos_stall  (pos_stall),
    .pos        (pos)
  );

endmodule
